>>> sv/ctp_pkg.sv
// shared widths, status codes and stage payload types for the circumcircle block
package ctp_pkg;

  localparam int CW   = 32;   // coordinate width
  localparam int DW   = 33;   // coordinate difference width
  localparam int SBW  = 66;   // sum of two squares
  localparam int HW   = 33;   // half split of a square sum
  localparam int MW   = 67;   // partial product width
  localparam int CRW  = 67;   // cross product width
  localparam int NW   = 100;  // numerator width
  localparam int DPW  = 68;   // doubled denominator width
  localparam int QB   = 35;   // quotient bits, one per divider cell
  localparam int RTW  = 33;   // square root result bits, one per root cell
  localparam int RMW  = 35;   // root remainder width
  localparam int SW   = 2 * RTW;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_COLL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // payload travelling along the divider chain, both quotients side by side
  typedef struct packed {
    logic                  coll;
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic [DPW-1:0]        dp;
    logic                  negx;
    logic                  negy;
    logic                  ovfx;
    logic                  ovfy;
    logic [DPW-1:0]        remx;
    logic [DPW-1:0]        remy;
    logic [QB-1:0]         nx_lo;
    logic [QB-1:0]         ny_lo;
    logic [QB-1:0]         qx;
    logic [QB-1:0]         qy;
  } ctp_div_t;

  // payload travelling along the square root chain
  typedef struct packed {
    logic                  coll;
    logic                  csat;
    logic                  rsat;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic [RMW-1:0]        rem;
    logic [RTW-1:0]        root;
    logic [SW-1:0]         s;
  } ctp_sqrt_t;

endpackage

>>> sv/ctp_if.sv
// valid/ready channels for point triples and circle results
interface ctp_in_if import ctp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic signed [CW-1:0] bx;
  logic signed [CW-1:0] by;
  logic signed [CW-1:0] qx;
  logic signed [CW-1:0] qy;

  modport source (output valid, ax, ay, bx, by, qx, qy, input ready);
  modport sink   (input valid, ax, ay, bx, by, qx, qy, output ready);
endinterface

interface ctp_out_if import ctp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic [CW-1:0]        radius;
  logic [1:0]           status;

  modport source (output valid, center_x, center_y, radius, status, input ready);
  modport sink   (input valid, center_x, center_y, radius, status, output ready);
endinterface

>>> sv/ctp_front.sv
// front pipeline: differences, products, numerators and divider set-up
module ctp_front import ctp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_i,
  input  logic signed [CW-1:0] qx_i,
  input  logic signed [CW-1:0] qy_i,
  output logic                 valid_o,
  output ctp_div_t             div_o
);

  logic [7:0] vld_q;

  // stage 1
  logic signed [CW-1:0] ax1_q, ay1_q;
  logic signed [DW-1:0] bdx1_q, bdy1_q, qdx1_q, qdy1_q;
  // stage 2
  logic signed [CW-1:0] ax2_q, ay2_q;
  logic signed [DW-1:0] bdx2_q, bdy2_q, qdx2_q, qdy2_q;
  logic signed [2*DW-1:0] pbx_q, pby_q, pqx_q, pqy_q, pc1_q, pc2_q;
  // stage 3
  logic signed [CW-1:0] ax3_q, ay3_q;
  logic signed [DW-1:0] bdx3_q, bdy3_q, qdx3_q, qdy3_q;
  logic [SBW-1:0]       sb3_q, sq3_q;
  logic signed [CRW-1:0] cr3_q;
  // stage 4
  logic signed [CW-1:0] ax4_q, ay4_q;
  logic signed [CRW-1:0] cr4_q;
  logic signed [MW-1:0] m1l_q, m1h_q, m2l_q, m2h_q, m3l_q, m3h_q, m4l_q, m4h_q;
  // stage 5
  logic signed [CW-1:0] ax5_q, ay5_q;
  logic signed [CRW-1:0] cr5_q;
  logic signed [NW-1:0] p1_q, p2_q, p3_q, p4_q;
  // stage 6
  logic signed [CW-1:0] ax6_q, ay6_q;
  logic signed [NW-1:0] nx6_q, ny6_q;
  logic signed [DPW-1:0] d6_q;
  logic                 coll6_q;
  // stage 7
  logic signed [CW-1:0] ax7_q, ay7_q;
  logic [NW-1:0]        nnx7_q, nny7_q;
  logic [DPW-1:0]       dp7_q;
  logic                 negx7_q, negy7_q, coll7_q;
  // stage 8
  ctp_div_t             div8_q;

  logic [NW-1:0]  anx_d, any_d;
  logic [DPW-1:0] ad_d;
  logic [DPW-1:0] hix_d, hiy_d;

  always_comb begin
    anx_d = nx6_q[NW-1] ? NW'(-nx6_q) : NW'(nx6_q);
    any_d = ny6_q[NW-1] ? NW'(-ny6_q) : NW'(ny6_q);
    ad_d  = d6_q[DPW-1] ? DPW'(-d6_q) : DPW'(d6_q);
    hix_d = DPW'(nnx7_q[NW-1:QB]);
    hiy_d = DPW'(nny7_q[NW-1:QB]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q  <= ax_i;
      ay1_q  <= ay_i;
      bdx1_q <= DW'(bx_i) - DW'(ax_i);
      bdy1_q <= DW'(by_i) - DW'(ay_i);
      qdx1_q <= DW'(qx_i) - DW'(ax_i);
      qdy1_q <= DW'(qy_i) - DW'(ay_i);

      ax2_q  <= ax1_q;  ay2_q  <= ay1_q;
      bdx2_q <= bdx1_q; bdy2_q <= bdy1_q; qdx2_q <= qdx1_q; qdy2_q <= qdy1_q;
      pbx_q  <= bdx1_q * bdx1_q;
      pby_q  <= bdy1_q * bdy1_q;
      pqx_q  <= qdx1_q * qdx1_q;
      pqy_q  <= qdy1_q * qdy1_q;
      pc1_q  <= bdx1_q * qdy1_q;
      pc2_q  <= bdy1_q * qdx1_q;

      ax3_q  <= ax2_q;  ay3_q  <= ay2_q;
      bdx3_q <= bdx2_q; bdy3_q <= bdy2_q; qdx3_q <= qdx2_q; qdy3_q <= qdy2_q;
      sb3_q  <= SBW'(pbx_q) + SBW'(pby_q);
      sq3_q  <= SBW'(pqx_q) + SBW'(pqy_q);
      cr3_q  <= CRW'(pc1_q) - CRW'(pc2_q);

      // split wide products into narrow partials, combined next stage
      ax4_q <= ax3_q; ay4_q <= ay3_q; cr4_q <= cr3_q;
      m1l_q <= qdy3_q * $signed({1'b0, sb3_q[HW-1:0]});
      m1h_q <= qdy3_q * $signed({1'b0, sb3_q[SBW-1:HW]});
      m2l_q <= bdy3_q * $signed({1'b0, sq3_q[HW-1:0]});
      m2h_q <= bdy3_q * $signed({1'b0, sq3_q[SBW-1:HW]});
      m3l_q <= bdx3_q * $signed({1'b0, sq3_q[HW-1:0]});
      m3h_q <= bdx3_q * $signed({1'b0, sq3_q[SBW-1:HW]});
      m4l_q <= qdx3_q * $signed({1'b0, sb3_q[HW-1:0]});
      m4h_q <= qdx3_q * $signed({1'b0, sb3_q[SBW-1:HW]});

      ax5_q <= ax4_q; ay5_q <= ay4_q; cr5_q <= cr4_q;
      p1_q  <= $signed({m1h_q, {HW{1'b0}}}) + NW'(m1l_q);
      p2_q  <= $signed({m2h_q, {HW{1'b0}}}) + NW'(m2l_q);
      p3_q  <= $signed({m3h_q, {HW{1'b0}}}) + NW'(m3l_q);
      p4_q  <= $signed({m4h_q, {HW{1'b0}}}) + NW'(m4l_q);

      ax6_q   <= ax5_q; ay6_q <= ay5_q;
      nx6_q   <= p1_q - p2_q;
      ny6_q   <= p3_q - p4_q;
      d6_q    <= $signed({cr5_q, 1'b0});
      coll6_q <= (cr5_q == '0);

      // rounding to nearest: (2|n| + |d|) / (2|d|)
      ax7_q   <= ax6_q; ay7_q <= ay6_q; coll7_q <= coll6_q;
      negx7_q <= nx6_q[NW-1] ^ d6_q[DPW-1];
      negy7_q <= ny6_q[NW-1] ^ d6_q[DPW-1];
      nnx7_q  <= {anx_d[NW-2:0], 1'b0} + NW'(ad_d);
      nny7_q  <= {any_d[NW-2:0], 1'b0} + NW'(ad_d);
      dp7_q   <= {ad_d[DPW-2:0], 1'b0};

      div8_q.coll  <= coll7_q;
      div8_q.ax    <= ax7_q;
      div8_q.ay    <= ay7_q;
      div8_q.dp    <= dp7_q;
      div8_q.negx  <= negx7_q;
      div8_q.negy  <= negy7_q;
      div8_q.ovfx  <= hix_d >= dp7_q;
      div8_q.ovfy  <= hiy_d >= dp7_q;
      div8_q.remx  <= hix_d;
      div8_q.remy  <= hiy_d;
      div8_q.nx_lo <= nnx7_q[QB-1:0];
      div8_q.ny_lo <= nny7_q[QB-1:0];
      div8_q.qx    <= '0;
      div8_q.qy    <= '0;
    end
  end

  assign valid_o = vld_q[7];
  assign div_o   = div8_q;

endmodule

>>> sv/ctp_div_cell.sv
// one restoring division cell: one quotient bit of both centre offsets
module ctp_div_cell import ctp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  ctp_div_t data_i,
  output logic     valid_o,
  output ctp_div_t data_o
);

  logic     valid_q;
  ctp_div_t data_q, data_d;
  logic [DPW:0] tx, ty;
  logic         bx, by;

  always_comb begin
    data_d = data_i;
    tx = {data_i.remx, data_i.nx_lo[QB-1]};
    ty = {data_i.remy, data_i.ny_lo[QB-1]};
    bx = tx >= {1'b0, data_i.dp};
    by = ty >= {1'b0, data_i.dp};
    data_d.remx  = bx ? DPW'(tx - {1'b0, data_i.dp}) : DPW'(tx);
    data_d.remy  = by ? DPW'(ty - {1'b0, data_i.dp}) : DPW'(ty);
    data_d.nx_lo = {data_i.nx_lo[QB-2:0], 1'b0};
    data_d.ny_lo = {data_i.ny_lo[QB-2:0], 1'b0};
    data_d.qx    = {data_i.qx[QB-2:0], bx};
    data_d.qy    = {data_i.qy[QB-2:0], by};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/ctp_sqrt_cell.sv
// one digit-recurrence square root cell: one root bit per cell
module ctp_sqrt_cell import ctp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  ctp_sqrt_t data_i,
  output logic      valid_o,
  output ctp_sqrt_t data_o
);

  logic      valid_q;
  ctp_sqrt_t data_q, data_d;
  logic [RMW+1:0] t, trial;
  logic           take;

  always_comb begin
    data_d = data_i;
    t      = {data_i.rem, data_i.s[SW-1:SW-2]};
    trial  = (RMW+2)'({data_i.root, 2'b01});
    take   = t >= trial;
    data_d.rem  = take ? RMW'(t - trial) : RMW'(t);
    data_d.root = {data_i.root[RTW-2:0], take};
    data_d.s    = {data_i.s[SW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/circle_through_three_points.sv
// top level: circle through three points, fully pipelined
//
// in_i carries one point triple (a, b, q) per transfer, signed Q16.16 coordinates.
// out_o carries centre x/y (signed Q16.16), radius (unsigned Q16.16) and a status
// code: ok, collinear/coincident (all result fields zero) or saturated.
// throughput: one triple per cycle while the receiver does not stall; the
// pipeline from input transfer to output valid is 8 front stages of products
// and numerators, 35 divider cells each giving one quotient bit, 3
// centre/square stages, 33 root cells and one output register.
// when the receiver stalls (valid high, ready low) the whole pipeline holds
// and in_i.ready falls; an empty output register lets everything advance.
// reset clears every stage valid bit and the output valid; data registers
// are not reset. no configuration, no kept state between items.
module circle_through_three_points import ctp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ctp_in_if.sink            in_i,
  ctp_out_if.source         out_o
);

  localparam logic signed [CW:0] CMAX = (CW+1)'((64'sd1 <<< (CW-1)) - 64'sd1);
  localparam logic signed [CW:0] CMIN = -((CW+1)'(64'sd1 <<< (CW-1)));

  logic en;                  // pipeline advance
  logic out_valid_q;

  // front end
  logic     fr_valid;
  ctp_div_t fr_div;

  ctp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .ax_i    (in_i.ax),
    .ay_i    (in_i.ay),
    .bx_i    (in_i.bx),
    .by_i    (in_i.by),
    .qx_i    (in_i.qx),
    .qy_i    (in_i.qy),
    .valid_o (fr_valid),
    .div_o   (fr_div)
  );

  // divider chain, one quotient bit per cell
  logic     dv_valid [QB+1];
  ctp_div_t dv_data  [QB+1];

  assign dv_valid[0] = fr_valid;
  assign dv_data[0]  = fr_div;

  for (genvar i = 0; i < QB; i++) begin : g_div
    ctp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[i]),
      .data_i  (dv_data[i]),
      .valid_o (dv_valid[i+1]),
      .data_o  (dv_data[i+1])
    );
  end

  // centre stage: sign the quotients, add point a, clamp
  ctp_div_t              dq;
  logic signed [QB:0]    ux, uy;
  logic signed [QB+1:0]  sx, sy;
  logic signed [CW-1:0]  cx_d, cy_d;
  logic                  satx_d, saty_d, rsat_d;

  always_comb begin
    dq = dv_data[QB];
    ux = dq.negx ? -$signed({1'b0, dq.qx}) : $signed({1'b0, dq.qx});
    uy = dq.negy ? -$signed({1'b0, dq.qy}) : $signed({1'b0, dq.qy});
    sx = (QB+2)'(dq.ax) + (QB+2)'(ux);
    sy = (QB+2)'(dq.ay) + (QB+2)'(uy);
    satx_d = 1'b1;
    saty_d = 1'b1;
    if (dq.ovfx) begin
      cx_d = dq.negx ? CW'(CMIN) : CW'(CMAX);
    end else if (sx > (QB+2)'(CMAX)) begin
      cx_d = CW'(CMAX);
    end else if (sx < (QB+2)'(CMIN)) begin
      cx_d = CW'(CMIN);
    end else begin
      cx_d   = CW'(sx);
      satx_d = 1'b0;
    end
    if (dq.ovfy) begin
      cy_d = dq.negy ? CW'(CMIN) : CW'(CMAX);
    end else if (sy > (QB+2)'(CMAX)) begin
      cy_d = CW'(CMAX);
    end else if (sy < (QB+2)'(CMIN)) begin
      cy_d = CW'(CMIN);
    end else begin
      cy_d   = CW'(sy);
      saty_d = 1'b0;
    end
    // offset of 2^32 or more always saturates the radius
    rsat_d = dq.ovfx || dq.ovfy || (dq.qx[QB-1:CW] != '0) || (dq.qy[QB-1:CW] != '0);
  end

  logic                 p1_valid_q, p2_valid_q, p3_valid_q;
  logic                 p1_coll_q, p1_csat_q, p1_rsat_q;
  logic signed [CW-1:0] p1_cx_q, p1_cy_q;
  logic [CW-1:0]        p1_mx_q, p1_my_q;
  logic                 p2_coll_q, p2_csat_q, p2_rsat_q;
  logic signed [CW-1:0] p2_cx_q, p2_cy_q;
  logic [2*CW-1:0]      p2_sx_q, p2_sy_q;
  ctp_sqrt_t            p3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= dv_valid[QB];
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_coll_q <= dq.coll;
      p1_csat_q <= satx_d || saty_d;
      p1_rsat_q <= rsat_d;
      p1_cx_q   <= cx_d;
      p1_cy_q   <= cy_d;
      p1_mx_q   <= dq.qx[CW-1:0];
      p1_my_q   <= dq.qy[CW-1:0];

      // squared offsets for the radius
      p2_coll_q <= p1_coll_q;
      p2_csat_q <= p1_csat_q;
      p2_rsat_q <= p1_rsat_q;
      p2_cx_q   <= p1_cx_q;
      p2_cy_q   <= p1_cy_q;
      p2_sx_q   <= p1_mx_q * p1_mx_q;
      p2_sy_q   <= p1_my_q * p1_my_q;

      p3_q.coll <= p2_coll_q;
      p3_q.csat <= p2_csat_q;
      p3_q.rsat <= p2_rsat_q;
      p3_q.cx   <= p2_cx_q;
      p3_q.cy   <= p2_cy_q;
      p3_q.rem  <= '0;
      p3_q.root <= '0;
      p3_q.s    <= SW'(p2_sx_q) + SW'(p2_sy_q);
    end
  end

  // square root chain, one root bit per cell
  logic      sq_valid [RTW+1];
  ctp_sqrt_t sq_data  [RTW+1];

  assign sq_valid[0] = p3_valid_q;
  assign sq_data[0]  = p3_q;

  for (genvar j = 0; j < RTW; j++) begin : g_sqrt
    ctp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[j]),
      .data_i  (sq_data[j]),
      .valid_o (sq_valid[j+1]),
      .data_o  (sq_data[j+1])
    );
  end

  // output register
  ctp_sqrt_t            sr;
  logic                 rad_sat;
  logic signed [CW-1:0] out_cx_q, out_cy_q;
  logic [CW-1:0]        out_rad_q;
  logic [1:0]           out_st_q;

  assign sr      = sq_data[RTW];
  assign rad_sat = sr.rsat || sr.root[RTW-1];
  assign en      = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sq_valid[RTW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sr.coll) begin
        // collinear or coincident points win over saturation
        out_cx_q  <= '0;
        out_cy_q  <= '0;
        out_rad_q <= '0;
        out_st_q  <= ST_COLL;
      end else begin
        out_cx_q  <= sr.cx;
        out_cy_q  <= sr.cy;
        out_rad_q <= rad_sat ? '1 : sr.root[CW-1:0];
        out_st_q  <= (sr.csat || rad_sat) ? ST_SAT : ST_OK;
      end
    end
  end

  assign in_i.ready     = en;
  assign out_o.valid    = out_valid_q;
  assign out_o.center_x = out_cx_q;
  assign out_o.center_y = out_cy_q;
  assign out_o.radius   = out_rad_q;
  assign out_o.status   = out_st_q;

  // collinear result carries zero fields
  a_coll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_st_q == ST_COLL |-> out_cx_q == '0 && out_cy_q == '0
      && out_rad_q == '0)
    else $error("collinear result with nonzero fields");

  // input side stalls exactly when the output register is full and blocked
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_valid_q || out_o.ready))
    else $error("input ready does not follow pipeline advance");

  // a stalled pipeline keeps the valid bit of its last root cell
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sq_valid[RTW]))
    else $error("root chain moved during stall");

  // an ok result never carries a saturated radius
  a_ok_rad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && sq_valid[RTW] && !sr.coll && rad_sat |=> out_st_q == ST_SAT)
    else $error("saturated radius without saturation status");

endmodule
